[rtl/ric_pkg.sv]
// Shared types and constants for the reference-counted inode cache.
package ric_pkg;

  // Field widths fixed by the interface.
  localparam int DEVICE_W = 16;
  localparam int INODE_W  = 12;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int SECTOR_W = 16;
  localparam int OFFSET_W = 4;
  localparam int IMAP_W   = 8;
  localparam int SMAP_W   = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  // Default configuration of the table.
  localparam int DEFAULT_TABLE_SLOTS       = 32;
  localparam int DEFAULT_INODES_PER_SECTOR = 16;

  // The boot sector and the super block precede the bitmaps.
  localparam logic [SECTOR_W-1:0] LEAD_SECTORS = SECTOR_W'(1 + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FREE_REL = 3'd5;

  // Command codes.
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMAP = 1'b1;

  // One slot of the table as stored in memory.
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [DEVICE_W-1:0] device;
    logic [INODE_W-1:0]  inode;
  } entry_t;

endpackage

[rtl/ric_slot_ram.sv]
// Slot table memory with one read and one write port and per-slot valid bits.
module ric_slot_ram #(
  parameter int TABLE_SLOTS = ric_pkg::DEFAULT_TABLE_SLOTS,
  parameter int ADDR_W      = $clog2(TABLE_SLOTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ADDR_W-1:0]   rd_addr,
  output ric_pkg::entry_t     rd_entry,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ric_pkg::entry_t     wr_entry
);
  import ric_pkg::*;

  entry_t                 mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid;
  entry_t                 rd_raw;
  logic                   rd_valid;

  // Storage array: registered read, single write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_raw <= mem[rd_addr];
  end

  // Valid bits make a slot that was never written read as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // Never-written slots show a zero count.
  always_comb begin
    rd_entry        = rd_raw;
    rd_entry.count  = rd_valid ? rd_raw.count : '0;
  end

endmodule

[rtl/ric_sector_calc.sv]
// Two-stage computation of the disk sector and entry offset of an inode.
module ric_sector_calc #(
  parameter int INODES_PER_SECTOR = ric_pkg::DEFAULT_INODES_PER_SECTOR
) (
  input  logic                          clk,
  input  logic [ric_pkg::INODE_W-1:0]   index,
  input  logic [ric_pkg::IMAP_W-1:0]    imap_sectors,
  input  logic [ric_pkg::SMAP_W-1:0]    smap_sectors,
  output logic [ric_pkg::SECTOR_W-1:0]  sector,
  output logic [ric_pkg::OFFSET_W-1:0]  offset
);
  import ric_pkg::*;

  // Reciprocal multiplication, exact for every index of INODE_W bits.
  localparam int SHIFT  = INODE_W + $clog2(INODES_PER_SECTOR);
  localparam int MULT   = ((1 << SHIFT) + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR;
  localparam int MULT_W = SHIFT + 1;
  localparam int PROD_W = INODE_W + MULT_W;
  localparam int IPS_W  = $clog2(INODES_PER_SECTOR + 1);
  localparam int REM_W  = INODE_W + IPS_W;

  logic [PROD_W-1:0]  product;
  logic [INODE_W-1:0] quot;
  logic [INODE_W-1:0] index_d;
  logic [REM_W-1:0]   quot_scaled;
  logic [REM_W-1:0]   remainder;

  assign product = PROD_W'(index) * PROD_W'(MULT_W'(MULT));

  // First stage: quotient.
  always_ff @(posedge clk) begin
    quot    <= product[SHIFT +: INODE_W];
    index_d <= index;
  end

  assign quot_scaled = REM_W'(quot) * REM_W'(IPS_W'(INODES_PER_SECTOR));
  assign remainder   = REM_W'(index_d) - quot_scaled;

  // Second stage: remainder and sector sum.
  always_ff @(posedge clk) begin
    offset <= remainder[OFFSET_W-1:0];
    sector <= LEAD_SECTORS + SECTOR_W'(imap_sectors) + SECTOR_W'(smap_sectors)
              + SECTOR_W'(quot);
  end

endmodule

[rtl/refcounted_inode_cache.sv]
// Top level of the reference-counted inode cache.
//
//   Channel  Signals                                   Direction  Transfer when
//   in       command device inode_number release_slot   in         in_valid & in_ready
//   out      status slot fetch_sector entry_offset      out        out_valid & out_ready
//            use_count
//   cfg      cfg_index cfg_data                         in         cfg_write
//
// An acquire is accepted, reads the slot memory once per slot and then updates the slot.
// A release, a zero inode or an out-of-range slot is accepted and answered without a scan.
// Reset clears every count at once through the valid bits; no clearing pass.
// A result held on a stalled output blocks only the final update cycle of the next item.
module refcounted_inode_cache #(
  parameter int TABLE_SLOTS       = ric_pkg::DEFAULT_TABLE_SLOTS,
  parameter int INODES_PER_SECTOR = ric_pkg::DEFAULT_INODES_PER_SECTOR
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [ric_pkg::DEVICE_W-1:0]    device,
  input  logic [ric_pkg::INODE_W-1:0]     inode_number,
  input  logic [ric_pkg::SLOT_W-1:0]      release_slot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ric_pkg::STATUS_W-1:0]    status,
  output logic [ric_pkg::SLOT_W-1:0]      slot,
  output logic [ric_pkg::SECTOR_W-1:0]    fetch_sector,
  output logic [ric_pkg::OFFSET_W-1:0]    entry_offset,
  output logic [ric_pkg::COUNT_W-1:0]     use_count,
  input  logic                            cfg_write,
  input  logic [ric_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ric_pkg::CFG_W-1:0]       cfg_data
);
  import ric_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RELEASE,
    S_REPLY
  } state_t;

  state_t               state;
  logic                 cmd_q;
  logic [DEVICE_W-1:0]  dev_q;
  logic [INODE_W-1:0]   num_q;
  logic [INODE_W-1:0]   index_q;
  logic [SLOT_W-1:0]    rel_q;
  logic [ADDR_W-1:0]    rel_addr_q;
  logic [ADDR_W-1:0]    chk_idx;
  logic                 hit_found;
  logic [ADDR_W-1:0]    hit_idx;
  logic [COUNT_W-1:0]   hit_count;
  logic                 free_found;
  logic [ADDR_W-1:0]    free_idx;
  logic [IMAP_W-1:0]    imap_sectors;
  logic [SMAP_W-1:0]    smap_sectors;

  logic [ADDR_W-1:0]    rd_addr;
  entry_t               rd_entry;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_entry;

  logic [SECTOR_W-1:0]  calc_sector;
  logic [OFFSET_W-1:0]  calc_offset;

  logic [31:0]          rel_wide;
  logic [ADDR_W-1:0]    rel_addr_in;
  logic                 rel_in_range;
  logic                 in_fire;
  logic                 out_free;
  logic                 in_use;
  logic                 tag_match;

  logic                 load_out;
  logic [STATUS_W-1:0]  res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [SECTOR_W-1:0]  res_sector;
  logic [OFFSET_W-1:0]  res_offset;
  logic [COUNT_W-1:0]   res_count;
  logic [31:0]          idx_wide;
  logic [COUNT_W-1:0]   hit_count_next;

  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign rel_wide     = 32'(release_slot);
  assign rel_addr_in  = rel_wide[ADDR_W-1:0];
  assign rel_in_range = (rel_wide < 32'(TABLE_SLOTS));

  assign in_use    = (rd_entry.count != '0);
  assign tag_match = in_use && (rd_entry.device == dev_q) && (rd_entry.inode == num_q);
  assign hit_count_next = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + 1'b1;

  ric_slot_ram #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .ADDR_W      (ADDR_W)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  ric_sector_calc #(
    .INODES_PER_SECTOR (INODES_PER_SECTOR)
  ) u_calc (
    .clk          (clk),
    .index        (index_q),
    .imap_sectors (imap_sectors),
    .smap_sectors (smap_sectors),
    .sector       (calc_sector),
    .offset       (calc_offset)
  );

  // Memory read address: the slot to look at in the next cycle.
  always_comb begin
    rd_addr = '0;
    case (state)
      S_IDLE:    rd_addr = (command == CMD_RELEASE) ? rel_addr_in : '0;
      S_SCAN:    rd_addr = (chk_idx == LAST_SLOT) ? '0 : chk_idx + 1'b1;
      S_RELEASE: rd_addr = rel_addr_q;
      default:   rd_addr = '0;
    endcase
  end

  // Result selection and slot update for the closing cycle of each item.
  always_comb begin
    load_out   = 1'b0;
    res_status = ST_ZERO;
    res_slot   = '0;
    res_sector = '0;
    res_offset = '0;
    res_count  = '0;
    idx_wide   = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_entry   = '{count: '0, device: dev_q, inode: num_q};
    case (state)
      S_DECIDE: begin
        load_out = out_free;
        if (hit_found) begin
          idx_wide       = 32'(hit_idx);
          res_status     = ST_HIT;
          res_slot       = idx_wide[SLOT_W-1:0];
          res_count      = hit_count_next;
          wr_en          = out_free;
          wr_addr        = hit_idx;
          wr_entry.count = hit_count_next;
        end else if (free_found) begin
          idx_wide       = 32'(free_idx);
          res_status     = ST_ALLOC;
          res_slot       = idx_wide[SLOT_W-1:0];
          res_sector     = calc_sector;
          res_offset     = calc_offset;
          res_count      = COUNT_W'(1);
          wr_en          = out_free;
          wr_addr        = free_idx;
          wr_entry.count = COUNT_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      S_RELEASE: begin
        load_out = out_free;
        res_slot = rel_q;
        if (rd_entry.count == '0) begin
          res_status = ST_FREE_REL;
        end else begin
          res_status = ST_RELEASED;
          res_count  = rd_entry.count - 1'b1;
          wr_en      = out_free;
          wr_addr    = rel_addr_q;
          wr_entry   = '{count: rd_entry.count - 1'b1, device: rd_entry.device,
                         inode: rd_entry.inode};
        end
      end
      S_REPLY: begin
        load_out = out_free;
        if (cmd_q == CMD_RELEASE) begin
          res_status = ST_FREE_REL;
          res_slot   = rel_q;
        end else begin
          res_status = ST_ZERO;
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      imap_sectors <= IMAP_W'(1);
      smap_sectors <= SMAP_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAP: imap_sectors <= cfg_data[IMAP_W-1:0];
        CFG_SMAP: smap_sectors <= cfg_data[SMAP_W-1:0];
        default:  imap_sectors <= imap_sectors;
      endcase
    end
  end

  // Request capture; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q      <= command;
      dev_q      <= device;
      num_q      <= inode_number;
      index_q    <= inode_number - 1'b1;
      rel_q      <= release_slot;
      rel_addr_q <= rel_addr_in;
    end
  end

  // Sequencer, scan bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      chk_idx    <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid    <= 1'b1;
        status       <= res_status;
        slot         <= res_slot;
        fetch_sector <= res_sector;
        entry_offset <= res_offset;
        use_count    <= res_count;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            chk_idx    <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (command == CMD_RELEASE) begin
              state <= rel_in_range ? S_RELEASE : S_REPLY;
            end else begin
              state <= (inode_number == '0) ? S_REPLY : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // The slot read last cycle is compared now; the first match wins.
          if (tag_match && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= chk_idx;
            hit_count <= rd_entry.count;
          end
          if (!in_use && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          chk_idx <= chk_idx + 1'b1;
          if (chk_idx == LAST_SLOT) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE, S_RELEASE, S_REPLY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An allocation always leaves the slot with a single user.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ALLOC) |-> (use_count == COUNT_W'(1)))
    else $error("allocation result with a count other than one");

  // Full and zero-inode results carry all-zero fields.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_FULL) || (status == ST_ZERO))
    |-> (slot == '0) && (use_count == '0) && (fetch_sector == '0) && (entry_offset == '0))
    else $error("full or zero-inode result with nonzero fields");

  // Only an allocation names a sector to fetch.
  a_sector_alloc_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ALLOC) |-> (fetch_sector == '0) && (entry_offset == '0))
    else $error("sector reported without allocation");

  // The slot memory is updated only together with the result it belongs to.
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> load_out && (state != S_IDLE) && (state != S_SCAN))
    else $error("slot write outside a closing cycle");

  // One item at a time: acceptance closes the input until the item is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an item is in progress");

endmodule

[sim/tb_refcounted_inode_cache.sv]
// Self-checking testbench for the reference-counted inode cache table.
`timescale 1ns / 1ps

module tb_refcounted_inode_cache;
  import ric_pkg::*;

  localparam int SLOTS         = DEFAULT_TABLE_SLOTS;
  localparam int PER_SECTOR    = DEFAULT_INODES_PER_SECTOR;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 60;

  // One predicted result of the cache.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_ACQUIRE;
  logic [DEVICE_W-1:0]  device = '0;
  logic [INODE_W-1:0]   inode_number = '0;
  logic [SLOT_W-1:0]    release_slot = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic [SECTOR_W-1:0]  fetch_sector;
  logic [OFFSET_W-1:0]  entry_offset;
  logic [COUNT_W-1:0]   use_count;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the table and the disk layout.
  logic [COUNT_W-1:0]  cache_count  [SLOTS];
  logic [DEVICE_W-1:0] cache_device [SLOTS];
  logic [INODE_W-1:0]  cache_inode  [SLOTS];
  logic [IMAP_W-1:0]   layout_imap = 8'd1;
  logic [SMAP_W-1:0]   layout_smap = 12'd1;

  outcome_t outcome_q[$];
  int       mismatches = 0;
  bit       gaps_on = 1'b1;

  // Random traffic draws from small pools so that hits and a full table occur.
  logic [DEVICE_W-1:0] dev_pool [4];
  logic [INODE_W-1:0]  ino_pool [12];

  refcounted_inode_cache u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .device       (device),
    .inode_number (inode_number),
    .release_slot (release_slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .fetch_sector (fetch_sector),
    .entry_offset (entry_offset),
    .use_count    (use_count),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pause lengths: mostly none or short, now and then long.
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Computes the outcome of one request and updates the shadow table.
  function automatic outcome_t cache_outcome(input logic cmd,
                                             input logic [DEVICE_W-1:0] dev,
                                             input logic [INODE_W-1:0] ino,
                                             input logic [SLOT_W-1:0] rel);
    outcome_t o;
    int hit_idx;
    int free_idx;
    int i;
    int unsigned ord;
    o = '0;
    hit_idx = -1;
    free_idx = -1;
    if (cmd == CMD_RELEASE) begin
      o.slot = rel;
      if (int'(rel) >= SLOTS || cache_count[rel] == '0) begin
        o.status = ST_FREE_REL;
      end else begin
        cache_count[rel] = cache_count[rel] - 1'b1;
        o.status = ST_RELEASED;
        o.count  = cache_count[rel];
      end
    end else if (ino == '0) begin
      o.status = ST_ZERO;
    end else begin
      // Tags only count while the slot is in use.
      for (i = 0; i < SLOTS; i++) begin
        if (cache_count[i] != '0) begin
          if (hit_idx < 0 && cache_device[i] == dev && cache_inode[i] == ino) hit_idx = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit_idx >= 0) begin
        if (cache_count[hit_idx] != COUNT_MAX) cache_count[hit_idx] = cache_count[hit_idx] + 1'b1;
        o.status = ST_HIT;
        o.slot   = SLOT_W'(hit_idx);
        o.count  = cache_count[hit_idx];
      end else if (free_idx < 0) begin
        o.status = ST_FULL;
      end else begin
        cache_device[free_idx] = dev;
        cache_inode[free_idx]  = ino;
        cache_count[free_idx]  = COUNT_W'(1);
        ord = int'(ino) - 1;
        o.status = ST_ALLOC;
        o.slot   = SLOT_W'(free_idx);
        o.sector = SECTOR_W'(int'(LEAD_SECTORS) + int'(layout_imap) + int'(layout_smap)
                             + ord / PER_SECTOR);
        o.offset = OFFSET_W'(ord % PER_SECTOR);
        o.count  = COUNT_W'(1);
      end
    end
    return o;
  endfunction

  // Picks a slot in use, or any slot if the table is empty.
  function automatic logic [SLOT_W-1:0] busy_slot();
    int start;
    int k;
    start = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      if (cache_count[(start + k) % SLOTS] != '0) return SLOT_W'((start + k) % SLOTS);
    end
    return SLOT_W'(start);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sends one request and records its outcome at the transfer.
  task automatic issue_request(input logic cmd, input logic [DEVICE_W-1:0] dev,
                               input logic [INODE_W-1:0] ino, input logic [SLOT_W-1:0] rel);
    int gap;
    gap = gaps_on ? pause_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    device       <= dev;
    inode_number <= ino;
    release_slot <= rel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(cache_outcome(cmd, dev, ino, rel));
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Writes both layout registers while the cache is idle.
  task automatic set_layout(input logic [IMAP_W-1:0] imap, input logic [SMAP_W-1:0] smap);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= CFG_IMAP;
    cfg_data  <= CFG_W'(imap);
    @(posedge clk);
    cfg_index <= CFG_SMAP;
    cfg_data  <= CFG_W'(smap);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    layout_imap = imap;
    layout_smap = smap;
  endtask

  // Releases every slot until the whole table is free.
  task automatic empty_table();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      while (cache_count[s] != '0) issue_request(CMD_RELEASE, 16'($urandom), '0, SLOT_W'(s));
    end
  endtask

  // Field extremes, sector boundaries, stale tags and releases of free slots.
  task automatic test_directed_cases();
    issue_request(CMD_ACQUIRE, 16'h1234, 12'h000, 5'd0);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'h001, 5'd0);
    issue_request(CMD_ACQUIRE, 16'hFFFF, 12'hFFF, 5'd31);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'h001, 5'd0);
    issue_request(CMD_ACQUIRE, 16'h0001, 12'h001, 5'd0);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'd16, 5'd0);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'd17, 5'd0);
    issue_request(CMD_RELEASE, 16'h0000, 12'h000, 5'd0);
    issue_request(CMD_RELEASE, 16'h0000, 12'h000, 5'd0);
    issue_request(CMD_RELEASE, 16'h0000, 12'h000, 5'd0);
    issue_request(CMD_RELEASE, 16'hFFFF, 12'hFFF, 5'd31);
    // A freed slot must not hit on its old tags.
    issue_request(CMD_ACQUIRE, 16'h0000, 12'h001, 5'd0);
    issue_request(CMD_RELEASE, 16'hFFFF, 12'hFFF, 5'd1);
    issue_request(CMD_ACQUIRE, 16'hFFFF, 12'hFFF, 5'd0);
    issue_request(CMD_ACQUIRE, 16'hFFFF, 12'h000, 5'd31);
    empty_table();
  endtask

  // Sector arithmetic across minimum and maximum bitmap sizes.
  task automatic test_layout_extremes();
    logic [IMAP_W-1:0] imaps [4];
    logic [SMAP_W-1:0] smaps [4];
    int k;
    imaps = '{8'd255, 8'd1, 8'd255, 8'd1};
    smaps = '{12'd4095, 12'd4095, 12'd1, 12'd1};
    for (k = 0; k < 4; k++) begin
      set_layout(imaps[k], smaps[k]);
      issue_request(CMD_ACQUIRE, 16'h0005, 12'hFFF, 5'd0);
      issue_request(CMD_ACQUIRE, 16'h0005, 12'h001, 5'd0);
      issue_request(CMD_ACQUIRE, 16'h0005, 12'h7F0, 5'd0);
      empty_table();
    end
  endtask

  // Fill every slot, then check full, zero inode, hit and reuse of a freed slot.
  task automatic test_table_full();
    int i;
    for (i = 0; i < SLOTS; i++) issue_request(CMD_ACQUIRE, 16'($urandom), INODE_W'(i + 1), '0);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'hFFF, 5'd0);
    issue_request(CMD_ACQUIRE, 16'hFFFF, 12'h000, 5'd0);
    issue_request(CMD_ACQUIRE, cache_device[5], cache_inode[5], 5'd0);
    issue_request(CMD_RELEASE, 16'h0000, 12'h000, 5'd7);
    issue_request(CMD_ACQUIRE, 16'h0000, 12'h800, 5'd0);
    issue_request(CMD_ACQUIRE, 16'h0001, 12'h800, 5'd0);
    empty_table();
  endtask

  // The use count stops at its maximum and counts down from there.
  task automatic test_count_saturation();
    int i;
    for (i = 0; i < 258; i++) issue_request(CMD_ACQUIRE, 16'hBEEF, 12'h800, 5'd0);
    for (i = 0; i < 3; i++) issue_request(CMD_RELEASE, 16'h0000, 12'h000, 5'd0);
    issue_request(CMD_ACQUIRE, 16'hBEEF, 12'h800, 5'd0);
  endtask

  // One random request: mostly pooled acquires and releases of busy slots.
  task automatic send_random_request(input int release_pct);
    int r;
    logic [SLOT_W-1:0] rel;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      issue_request(1'($urandom), 16'($urandom), 12'($urandom), 5'($urandom));
    end else if (r < release_pct) begin
      rel = ($urandom_range(0, 9) == 0) ? 5'($urandom) : busy_slot();
      issue_request(CMD_RELEASE, 16'($urandom), 12'($urandom), rel);
    end else if (r < release_pct + 5) begin
      issue_request(CMD_ACQUIRE, 16'($urandom), '0, 5'($urandom));
    end else begin
      issue_request(CMD_ACQUIRE, dev_pool[$urandom_range(0, 3)],
                    ino_pool[$urandom_range(0, 11)], 5'($urandom));
    end
  endtask

  // Random traffic in phases with different layouts, release rates and pacing.
  task automatic test_random_traffic();
    int i;
    int phase;
    int items;
    int rel_pct;
    dev_pool = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
    for (i = 0; i < 12; i++) ino_pool[i] = INODE_W'($urandom_range(1, 4095));
    ino_pool[0] = 12'h001;
    ino_pool[1] = 12'hFFF;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_layout(8'($urandom_range(1, 255)), 12'($urandom_range(1, 4095)));
          rel_pct = 45;
          items   = 200;
        end
        1: begin
          set_layout(8'd255, 12'd4095);
          rel_pct = 25;
          items   = 200;
        end
        2: begin
          set_layout(8'd1, 12'd1);
          rel_pct = 55;
          items   = 150;
        end
        default: begin
          set_layout(8'($urandom_range(1, 255)), 12'($urandom_range(1, 4095)));
          rel_pct = 40;
          items   = 190;
        end
      endcase
      // Phase two runs back to back with no sender gaps.
      gaps_on = (phase != 2);
      for (i = 0; i < items; i++) begin
        send_random_request(rel_pct);
        if (i == items / 2) drain_results();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence.
  initial begin : main_sequence
    int s;
    for (s = 0; s < SLOTS; s++) begin
      cache_count[s]  = '0;
      cache_device[s] = '0;
      cache_inode[s]  = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_layout_extremes();
    test_table_full();
    test_count_saturation();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("tb_refcounted_inode_cache OK");
    end else begin
      $display("tb_refcounted_inode_cache NOT OK");
    end
    $finish;
  end

  // Result side: runs of ready broken by stalls of random length.
  initial begin : sink_pacing
    int run;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pause_length();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compares each result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (outcome_q.size() == 0) begin
        $error("result with no request pending: status %0d slot %0d", status, slot);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("slot", 16'(want.slot), 16'(slot));
        check_field("fetch_sector", want.sector, fetch_sector);
        check_field("entry_offset", 16'(want.offset), 16'(entry_offset));
        check_field("use_count", 16'(want.count), 16'(use_count));
      end
    end
  end

  // Ends the run if no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_refcounted_inode_cache NOT OK");
    $finish;
  end

endmodule
